/* rtl/pwm_input_capture_assert.svh */
// Assertion macros shared by the PWM capture modules.
`ifndef PWM_INPUT_CAPTURE_ASSERT_SVH
`define PWM_INPUT_CAPTURE_ASSERT_SVH

// The condition holds at every clock edge out of reset.
`define PIC_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When the trigger holds, the condition holds in the same cycle.
`define PIC_ASSERT_IMPL(lbl, clk, rst_n, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error(msg);

// When the trigger holds, the condition holds in the next cycle.
`define PIC_ASSERT_NEXT(lbl, clk, rst_n, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

/* rtl/pic_pkg.sv */
// Shared constants, codes and types of the PWM input capture block.
package pic_pkg;

  localparam int CHANNELS    = 4;
  localparam int CH_IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [63:0]         usec_t;
  typedef logic [31:0]         width_t;
  typedef logic [2:0]          chan_t;
  typedef logic [CH_IDX_W-1:0] ch_idx_t;

  typedef enum logic {
    CMD_EDGE = 1'b0,
    CMD_READ = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_NEW      = 3'd0,
    STAT_NONE     = 3'd1,
    STAT_UNARMED  = 3'd2,
    STAT_BAD_CHAN = 3'd3,
    STAT_DISABLED = 3'd4
  } status_t;

  // Classified operation, as the front end hands it to the back end.
  typedef enum logic [1:0] {
    OP_EDGE,
    OP_READ,
    OP_READ_BAD,
    OP_READ_OFF
  } op_t;

  typedef struct packed {
    op_t     op;
    ch_idx_t ch;
    logic    level;
    usec_t   timestamp;
  } q_entry_t;

  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } q_wr_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_rd_t;

endpackage

/* rtl/pic_if.sv */
// Request and result channel interfaces of the PWM input capture block.
interface pic_in_if;
  import pic_pkg::*;

  logic  valid;
  logic  ready;
  logic  cmd;
  chan_t channel;
  logic  level;
  usec_t timestamp;

  modport source (output valid, output cmd, output channel, output level,
                  output timestamp, input ready);
  modport sink   (input valid, input cmd, input channel, input level,
                  input timestamp, output ready);
endinterface

interface pic_out_if;
  import pic_pkg::*;

  logic        valid;
  logic        ready;
  logic [2:0]  status;
  usec_t       pulse_start;
  width_t      high_width;
  usec_t       period_time;

  modport source (output valid, output status, output pulse_start, output high_width,
                  output period_time, input ready);
  modport sink   (input valid, input status, input pulse_start, input high_width,
                  input period_time, output ready);
endinterface

/* rtl/pic_front.sv */
// Front end: enable register, request acceptance and classification.
module pic_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic          cfg_wr_data,
  pic_in_if.sink        in_ch,
  input  logic          q_full,
  output pic_pkg::q_wr_t q_wr
);
  import pic_pkg::*;

  localparam logic [3:0] CHAN_LIMIT = 4'(CHANNELS);

  logic enable_r;
  logic enable_nxt;
  logic accept;
  logic chan_ok;
  logic is_read;
  op_t  op;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign chan_ok     = {1'b0, in_ch.channel} < CHAN_LIMIT;
  assign is_read     = (in_ch.cmd == CMD_READ);

  always_comb begin
    enable_nxt = cfg_wr_en ? cfg_wr_data : enable_r;
  end

  // Failing reads are decided here; the back end only sees the channel state.
  always_comb begin
    priority if (!is_read) begin
      op = OP_EDGE;
    end else if (!enable_r) begin
      op = OP_READ_OFF;
    end else if (!chan_ok) begin
      op = OP_READ_BAD;
    end else begin
      op = OP_READ;
    end
  end

  // Edges while disabled or on a channel out of range are dropped here.
  assign q_wr.push            = accept && (is_read || (enable_r && chan_ok));
  assign q_wr.entry.op        = op;
  assign q_wr.entry.ch        = in_ch.channel[CH_IDX_W-1:0];
  assign q_wr.entry.level     = in_ch.level;
  assign q_wr.entry.timestamp = in_ch.timestamp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
    end else begin
      enable_r <= enable_nxt;
    end
  end

endmodule

/* rtl/pic_queue.sv */
// Short request queue between the front end and the back end.
`include "pwm_input_capture_assert.svh"

module pic_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  pic_pkg::q_wr_t q_wr,
  output logic           q_full,
  output pic_pkg::q_rd_t q_rd,
  input  logic           q_pop
);
  import pic_pkg::*;

  localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(QUEUE_DEPTH - 1);
  localparam logic [QCNT_W-1:0] FULL_CNT = QCNT_W'(QUEUE_DEPTH);

  q_entry_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;

  assign q_full      = (count_r == FULL_CNT);
  assign q_rd.valid  = (count_r != '0);
  assign q_rd.entry  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (q_wr.push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({q_wr.push, q_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      mem_r[wr_ptr_r] <= q_wr.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `PIC_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= FULL_CNT, "queue count overflow")
  `PIC_ASSERT_IMPL(a_pop_not_empty, clk, rst_n, q_pop, count_r != '0, "pop from empty queue")

endmodule

/* rtl/pic_back.sv */
// Back end: per-channel capture state, snapshot and result register.
`include "pwm_input_capture_assert.svh"

module pic_back (
  input  logic           clk,
  input  logic           rst_n,
  input  pic_pkg::q_rd_t q_rd,
  output logic           q_pop,
  pic_out_if.source      out_ch
);
  import pic_pkg::*;

  logic    phase_r  [CHANNELS];
  logic    phase_nxt [CHANNELS];
  logic    armed_r  [CHANNELS];
  logic    armed_nxt [CHANNELS];
  logic    fresh_r  [CHANNELS];
  logic    fresh_nxt [CHANNELS];
  usec_t   rise_r   [CHANNELS];
  usec_t   rise_nxt [CHANNELS];
  usec_t   period_r [CHANNELS];
  usec_t   period_nxt [CHANNELS];
  width_t  width_r  [CHANNELS];
  width_t  width_nxt [CHANNELS];

  usec_t   snap_start_r;
  usec_t   snap_start_nxt;
  width_t  snap_width_r;
  width_t  snap_width_nxt;
  usec_t   snap_period_r;
  usec_t   snap_period_nxt;
  logic    out_valid_r;
  logic    out_valid_nxt;
  status_t out_status_r;
  status_t out_status_nxt;

  ch_idx_t head_ch;
  logic    is_edge;
  logic    out_free;
  logic    pop_read;
  logic    take_snap;
  logic    do_toggle;
  usec_t   diff;
  status_t status;

  assign head_ch   = q_rd.entry.ch;
  assign is_edge   = (q_rd.entry.op == OP_EDGE);
  assign out_free  = !out_valid_r || out_ch.ready;
  assign q_pop     = q_rd.valid && (is_edge || out_free);
  assign pop_read  = q_pop && !is_edge;
  assign diff      = q_rd.entry.timestamp - rise_r[head_ch];
  assign do_toggle = q_pop && is_edge && (armed_r[head_ch] || q_rd.entry.level);

  always_comb begin
    unique case (q_rd.entry.op)
      OP_READ_OFF: status = STAT_DISABLED;
      OP_READ_BAD: status = STAT_BAD_CHAN;
      default: begin
        priority if (!armed_r[head_ch]) begin
          status = STAT_UNARMED;
        end else if (!fresh_r[head_ch]) begin
          status = STAT_NONE;
        end else begin
          status = STAT_NEW;
        end
      end
    endcase
  end

  assign take_snap = pop_read && (q_rd.entry.op == OP_READ) && (status == STAT_NEW);

  always_comb begin
    phase_nxt       = phase_r;
    armed_nxt       = armed_r;
    fresh_nxt       = fresh_r;
    rise_nxt        = rise_r;
    period_nxt      = period_r;
    width_nxt       = width_r;
    snap_start_nxt  = snap_start_r;
    snap_width_nxt  = snap_width_r;
    snap_period_nxt = snap_period_r;
    out_status_nxt  = out_status_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;

    if (do_toggle) begin
      armed_nxt[head_ch] = 1'b1;
      if (!phase_r[head_ch]) begin
        phase_nxt[head_ch]  = 1'b1;
        period_nxt[head_ch] = diff;
        rise_nxt[head_ch]   = q_rd.entry.timestamp;
      end else begin
        phase_nxt[head_ch] = 1'b0;
        width_nxt[head_ch] = diff[31:0];
        fresh_nxt[head_ch] = 1'b1;
      end
    end

    if (take_snap) begin
      fresh_nxt[head_ch] = 1'b0;
      snap_start_nxt     = rise_r[head_ch];
      snap_width_nxt     = width_r[head_ch];
      snap_period_nxt    = period_r[head_ch];
    end

    if (pop_read) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        phase_r[i]  <= 1'b0;
        armed_r[i]  <= 1'b0;
        fresh_r[i]  <= 1'b0;
        rise_r[i]   <= '0;
        period_r[i] <= '0;
        width_r[i]  <= '0;
      end
      snap_start_r  <= '0;
      snap_width_r  <= '0;
      snap_period_r <= '0;
      out_valid_r   <= 1'b0;
      out_status_r  <= STAT_NEW;
    end else begin
      phase_r       <= phase_nxt;
      armed_r       <= armed_nxt;
      fresh_r       <= fresh_nxt;
      rise_r        <= rise_nxt;
      period_r      <= period_nxt;
      width_r       <= width_nxt;
      snap_start_r  <= snap_start_nxt;
      snap_width_r  <= snap_width_nxt;
      snap_period_r <= snap_period_nxt;
      out_valid_r   <= out_valid_nxt;
      out_status_r  <= out_status_nxt;
    end
  end

  // The snapshot registers drive the result payload directly; they only
  // change when a read leaves the queue, which waits for a free result slot.
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.pulse_start = snap_start_r;
  assign out_ch.high_width  = snap_width_r;
  assign out_ch.period_time = snap_period_r;

  `PIC_ASSERT_NEXT(a_read_gives_result, clk, rst_n, pop_read, out_valid_r, "read lost its result")
  `PIC_ASSERT_NEXT(a_snap_clears_fresh, clk, rst_n, take_snap, !fresh_r[$past(head_ch)], "flag kept")
  `PIC_ASSERT_ALWAYS(a_unarmed_idle, clk, rst_n, armed_r[0] || (!phase_r[0] && !fresh_r[0]), "bad state")

endmodule

/* rtl/pwm_input_capture.sv */
// Top level of the multi-channel PWM period and pulse-width capture block.
// Each request on in_ch is either a pin edge (cmd 0) or a read (cmd 1) for
// one channel. The block takes one request per clock cycle for as long as
// the result side keeps up: a front end checks the enable register and the
// channel range and drops edges that cannot count, a two-entry queue
// carries the rest, and a back end applies each request to the channel
// state, with a single 64-bit subtraction giving both period and high
// width. A read is written into the queue, and its result is then
// registered in the result register, which drives out_ch. The result then
// holds in the result register until out_ch accepts it. Edge requests
// produce no result. They wait for the result side only when a stalled
// read sits ahead of them in the queue.
// Reset clears all channel state and the snapshot at once, so no clearing
// pass is needed. The enable register should be written only while the
// block is idle.
module pwm_input_capture (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data,
  pic_in_if.sink    in_ch,
  pic_out_if.source out_ch
);
  import pic_pkg::*;

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  q_pop;

  // Front end: classification of each request.
  pic_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .q_full      (q_full),
    .q_wr        (q_wr)
  );

  // Decoupling queue.
  pic_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_rd   (q_rd),
    .q_pop  (q_pop)
  );

  // Back end: channel state, snapshot and results.
  pic_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_rd   (q_rd),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule
